@@ rtl/core/srtf_pkg.sv @@
// Shared types and constants of the SRTF scheduler.
`default_nettype none

package srtf_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int TIME_W_DEF = 16;

    localparam int FIELD_W = 16;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 32;

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [ADDR_W-1:0] ADDR_PROCESS_COUNT = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/srtf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/srtf_preemptive_scheduler.sv @@
// Top level of the preemptive shortest-remaining-time-first scheduler.
//
// channel   direction  handshake                       payload
// request   in         start && !busy                  action, slot, arrival, burst
// result    out        done (one cycle, no backpressure) finished, finished_slot,
//                                                      waiting_time, turnaround_ticks,
//                                                      idle, all_done
// config    in         psel && penable && pwrite       paddr, pwdata (prdata on read)
//
// A load request passes through ST_LOAD before the next acceptance; a tick
// walks ST_SCAN, ST_DRAIN and ST_UPDATE, its length set by the scan that
// reads the slot memory one entry per cycle through its single read port.
// done rises in the cycle busy falls, so a new request is taken while the
// result is shown. rst_n clears the remaining-time valid bits at once; no
// clearing pass is needed. The receiver cannot stall.
`default_nettype none

module srtf_preemptive_scheduler
    import srtf_pkg::*;
#(
    parameter int NUM_SLOTS  = SLOTS_DEF,
    parameter int TIME_WIDTH = TIME_W_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               action,
    input  wire logic [SLOT_W-1:0]  slot,
    input  wire logic [FIELD_W-1:0] arrival,
    input  wire logic [FIELD_W-1:0] burst,
    output logic                    done,
    output logic                    finished,
    output logic [SLOT_W-1:0]       finished_slot,
    output logic [FIELD_W-1:0]      waiting_time,
    output logic [FIELD_W-1:0]      turnaround_ticks,
    output logic                    idle,
    output logic                    all_done,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int CMP_W = (TIME_WIDTH > FIELD_W) ? TIME_WIDTH : FIELD_W;
    localparam int ENT_W = 3 * FIELD_W;
    localparam logic [SW-1:0]         LAST_IDX = SW'(NUM_SLOTS - 1);
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      process_count_reg, process_count_next;
    logic [NUM_SLOTS-1:0]  valid_reg, valid_next;
    logic [TIME_WIDTH-1:0] time_reg, time_next;
    logic [CNT_W-1:0]      done_count_reg, done_count_next;
    logic [SW-1:0]         scan_idx_reg, scan_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic                  best_found_reg, best_found_next;
    logic                  done_reg, done_next;

    logic [SW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                  req_action_reg, req_action_next;
    logic [SLOT_W-1:0]     req_slot_reg, req_slot_next;
    logic [FIELD_W-1:0]    req_arrival_reg, req_arrival_next;
    logic [FIELD_W-1:0]    req_burst_reg, req_burst_next;
    logic [SW-1:0]         best_idx_reg, best_idx_next;
    logic [FIELD_W-1:0]    best_rem_reg, best_rem_next;
    logic [FIELD_W-1:0]    best_arr_reg, best_arr_next;
    logic [FIELD_W-1:0]    best_burst_reg, best_burst_next;
    logic                  finished_reg, finished_next;
    logic [SLOT_W-1:0]     fslot_reg, fslot_next;
    logic [FIELD_W-1:0]    wait_reg, wait_next;
    logic [FIELD_W-1:0]    tat_reg, tat_next;
    logic                  idle_reg, idle_next;
    logic                  all_done_reg, all_done_next;

    logic                  ram_we;
    logic [SW-1:0]         ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [ENT_W-1:0]      ram_rdata;

    logic [FIELD_W-1:0]    rd_rem;
    logic [FIELD_W-1:0]    rd_burst;
    logic [FIELD_W-1:0]    rd_arr;
    logic                  rd_elig;
    logic                  take;
    logic                  slot_ok;
    logic                  cfg_wr;
    logic [TIME_WIDTH-1:0] end_time;
    logic [FIELD_W-1:0]    new_rem;
    logic [CMP_W-1:0]      tat_full;
    logic [CMP_W-1:0]      wait_full;

    srtf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign finished         = finished_reg;
    assign finished_slot    = fslot_reg;
    assign waiting_time     = wait_reg;
    assign turnaround_ticks = tat_reg;
    assign idle             = idle_reg;
    assign all_done         = all_done_reg;
    assign pready           = 1'b1;
    assign prdata           = (paddr == ADDR_PROCESS_COUNT) ?
                              DATA_W'(process_count_reg) : '0;

    assign cfg_wr   = psel && penable && pwrite && pready && (paddr == ADDR_PROCESS_COUNT);
    assign rd_rem   = ram_rdata[FIELD_W-1:0];
    assign rd_burst = ram_rdata[2*FIELD_W-1:FIELD_W];
    assign rd_arr   = ram_rdata[3*FIELD_W-1:2*FIELD_W];
    assign rd_elig  = valid_reg[cmp_idx_reg] && (rd_rem != '0) &&
                      (CMP_W'(rd_arr) <= CMP_W'(time_reg));
    assign take     = cmp_vld_reg && rd_elig && (!best_found_reg || (rd_rem < best_rem_reg));
    assign slot_ok  = (32'(req_slot_reg) < NUM_SLOTS);
    assign end_time = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 1'b1;
    assign new_rem  = best_rem_reg - 1'b1;
    assign tat_full = CMP_W'(end_time) - CMP_W'(best_arr_reg);
    assign wait_full = (tat_full >= CMP_W'(best_burst_reg)) ?
                       tat_full - CMP_W'(best_burst_reg) : '0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (action == ACT_TICK) ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_IDLE;
            ST_SCAN:   state_next = (scan_idx_reg == LAST_IDX) ? ST_DRAIN : ST_SCAN;
            ST_DRAIN:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        process_count_next = cfg_wr ? pwdata[CNT_W-1:0] : process_count_reg;
        valid_next         = valid_reg;
        time_next          = time_reg;
        done_count_next    = done_count_reg;
        scan_idx_next      = scan_idx_reg;
        cmp_vld_next       = 1'b0;
        cmp_idx_next       = scan_idx_reg;
        best_found_next    = best_found_reg;
        done_next          = 1'b0;
        req_action_next    = req_action_reg;
        req_slot_next      = req_slot_reg;
        req_arrival_next   = req_arrival_reg;
        req_burst_next     = req_burst_reg;
        best_idx_next      = best_idx_reg;
        best_rem_next      = best_rem_reg;
        best_arr_next      = best_arr_reg;
        best_burst_next    = best_burst_reg;
        finished_next      = finished_reg;
        fslot_next         = fslot_reg;
        wait_next          = wait_reg;
        tat_next           = tat_reg;
        idle_next          = idle_reg;
        all_done_next      = all_done_reg;
        ram_we             = 1'b0;
        ram_waddr          = SW'(req_slot_reg);
        ram_wdata          = {req_arrival_reg, req_burst_reg, req_burst_reg};

        if (take)
        begin
            best_found_next = 1'b1;
            best_idx_next   = cmp_idx_reg;
            best_rem_next   = rd_rem;
            best_arr_next   = rd_arr;
            best_burst_next = rd_burst;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_action_next  = action;
                    req_slot_next    = slot;
                    req_arrival_next = arrival;
                    req_burst_next   = burst;
                    scan_idx_next    = '0;
                    best_found_next  = 1'b0;
                end
            end
            ST_LOAD:
            begin
                if (slot_ok)
                begin
                    ram_we                      = 1'b1;
                    valid_next[SW'(req_slot_reg)] = 1'b1;
                end
                done_next     = 1'b1;
                finished_next = 1'b0;
                fslot_next    = '0;
                wait_next     = '0;
                tat_next      = '0;
                idle_next     = 1'b0;
                all_done_next = (done_count_reg >= process_count_reg);
            end
            ST_SCAN:
            begin
                cmp_vld_next = 1'b1;
                if (scan_idx_reg != LAST_IDX)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                done_next     = 1'b1;
                time_next     = end_time;
                finished_next = 1'b0;
                fslot_next    = '0;
                wait_next     = '0;
                tat_next      = '0;
                idle_next     = !best_found_reg;
                if (best_found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = best_idx_reg;
                    ram_wdata = {best_arr_reg, best_burst_reg, new_rem};
                    if (new_rem == '0)
                    begin
                        finished_next = 1'b1;
                        fslot_next    = SLOT_W'(best_idx_reg);
                        tat_next      = (tat_full > CMP_W'(FIELD_MAX)) ?
                                        FIELD_MAX : FIELD_W'(tat_full);
                        wait_next     = (wait_full > CMP_W'(FIELD_MAX)) ?
                                        FIELD_MAX : FIELD_W'(wait_full);
                        if (done_count_reg != CNT_MAX)
                        begin
                            done_count_next = done_count_reg + 1'b1;
                        end
                    end
                end
                all_done_next = (done_count_next >= process_count_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            process_count_reg <= '0;
            valid_reg         <= '0;
            time_reg          <= '0;
            done_count_reg    <= '0;
            scan_idx_reg      <= '0;
            cmp_vld_reg       <= 1'b0;
            best_found_reg    <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            process_count_reg <= process_count_next;
            valid_reg         <= valid_next;
            time_reg          <= time_next;
            done_count_reg    <= done_count_next;
            scan_idx_reg      <= scan_idx_next;
            cmp_vld_reg       <= cmp_vld_next;
            best_found_reg    <= best_found_next;
            done_reg          <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg     <= cmp_idx_next;
        req_action_reg  <= req_action_next;
        req_slot_reg    <= req_slot_next;
        req_arrival_reg <= req_arrival_next;
        req_burst_reg   <= req_burst_next;
        best_idx_reg    <= best_idx_next;
        best_rem_reg    <= best_rem_next;
        best_arr_reg    <= best_arr_next;
        best_burst_reg  <= best_burst_next;
        finished_reg    <= finished_next;
        fslot_reg       <= fslot_next;
        wait_reg        <= wait_next;
        tat_reg         <= tat_next;
        idle_reg        <= idle_next;
        all_done_reg    <= all_done_next;
    end

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_LOAD || $past(state_reg) == ST_UPDATE))
        else $error("result strobe without a finishing state");

    a_load_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (req_action_reg == ACT_LOAD))
        else $error("load state entered for a tick request");

    a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && best_found_reg) |-> (best_rem_reg != '0))
        else $error("chosen slot has no remaining time");

    a_finish_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && finished) |-> !idle)
        else $error("completion reported on an idle tick");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_UPDATE) |=> (time_reg == $past(time_reg)))
        else $error("time moved outside a tick update");

endmodule

`default_nettype wire
